@@ rtl/core/id3fp_pkg.sv @@
// id3fp_pkg: shared constants, result codes and the result bundle type
// for the id3v2 frame parser; no dependencies
`default_nettype none

package id3fp_pkg;

	// parser phases
	localparam logic [1:0] PH_HEADER    = 2'd0;
	localparam logic [1:0] PH_FRAME_HDR = 2'd1;
	localparam logic [1:0] PH_VALUE     = 2'd2;
	localparam logic [1:0] PH_IDLE      = 2'd3;

	// result kinds
	localparam logic [3:0] KIND_VERSION   = 4'd0;
	localparam logic [3:0] KIND_BEGIN     = 4'd1;
	localparam logic [3:0] KIND_VALUE     = 4'd2;
	localparam logic [3:0] KIND_UNSUP     = 4'd3;
	localparam logic [3:0] KIND_END       = 4'd4;
	localparam logic [3:0] KIND_NO_TAG    = 4'd5;
	localparam logic [3:0] KIND_BAD_VER   = 4'd6;
	localparam logic [3:0] KIND_NOT_FOUND = 4'd7;
	localparam logic [3:0] KIND_TAG_DONE  = 4'd8;

	// configuration register indexes
	localparam logic CFG_MATCH_MODE = 1'b0;
	localparam logic CFG_WANTED_ID  = 1'b1;

	localparam int POS_W     = 33;
	localparam int SIZE_W    = 28;
	localparam int TAG_END_W = 29;
	localparam int MAX_RES   = 4;

	localparam logic [3:0]           HDR_LAST_IDX = 4'd9;
	localparam logic [3:0]           SIZE_IDX     = 4'd6;
	localparam logic [3:0]           VER_IDX      = 4'd3;
	localparam logic [3:0]           REV_IDX      = 4'd4;
	localparam logic [3:0]           NAME_END_IDX = 4'd3;
	localparam logic [3:0]           LEN_END_IDX  = 4'd7;
	localparam logic [TAG_END_W-1:0] TAG_HDR_LEN  = 29'd10;
	localparam logic [7:0]           BYTE_NO_TAG  = 8'hFF;
	localparam logic [7:0]           VER_UNSUPP   = 8'd2;
	localparam logic [31:0]          ID_APIC      = 32'h41504943;
	localparam logic [31:0]          ID_COMM      = 32'h434F4D4D;
	localparam logic [15:0]          ID_TT        = 16'h5454;

	// all results caused by one input byte; they share every field but kind
	typedef struct packed {
		logic [MAX_RES-1:0][3:0] kinds;
		logic [2:0]              count;
		logic                    last;
		logic [7:0]              data;
		logic [31:0]             name;
		logic [31:0]             wanted;
		logic [7:0]              version;
		logic [7:0]              revision;
	} id3fp_bundle_t;

endpackage

`default_nettype wire

@@ rtl/core/id3fp_if.sv @@
// id3fp_in_if, id3fp_out_if: valid/ready channels of the id3v2 frame parser
// no dependencies
`default_nettype none

interface id3fp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       file_start;

	modport source (output valid, in_byte, file_start, input ready);
	modport sink (input valid, in_byte, file_start, output ready);
endinterface

interface id3fp_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [7:0]  data_byte;
	logic [31:0] frame_id;
	logic [7:0]  tag_version;
	logic [7:0]  tag_revision;
	logic        last;

	modport source (output valid, kind, data_byte, frame_id, tag_version, tag_revision, last,
		input ready);
	modport sink (input valid, kind, data_byte, frame_id, tag_version, tag_revision, last,
		output ready);
endinterface

`default_nettype wire

@@ rtl/core/id3fp_parser.sv @@
// id3fp_parser: tag and frame header state machine, one byte per step,
// producing the bundle of results for that byte; uses id3fp_pkg
`default_nettype none

module id3fp_parser
	import id3fp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    in_byte,
	input  wire logic          file_start,
	input  wire logic          match_mode,
	input  wire logic [31:0]   wanted_frame_id,
	output id3fp_bundle_t      bundle
);

	logic [1:0]           phase_q, phase_d;
	logic [3:0]           idx_q, idx_d;
	logic [7:0]           first_q, first_d;
	logic [7:0]           major_q, major_d;
	logic [7:0]           minor_q, minor_d;
	logic [SIZE_W-1:0]    size_q, size_d;
	logic [TAG_END_W-1:0] tag_end_q, tag_end_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	logic [31:0]          name_q, name_d;
	logic [31:0]          len_q, len_d;
	logic [31:0]          left_q, left_d;
	logic                 emit_q, emit_d;
	logic                 shown_q, shown_d;
	logic                 frame_final_q, frame_final_d;

	logic [1:0]           cur_phase;
	logic [3:0]           cur_idx;
	logic [POS_W-1:0]     cur_pos;
	logic [POS_W-1:0]     pos_inc;
	logic [MAX_RES-1:0][3:0] kinds;
	logic [2:0]           n;
	logic                 last_flag;
	logic                 do_finish;
	logic                 do_boundary;
	logic                 do_term;
	logic                 matched;
	logic                 unsup;

	always_comb begin
		// a file start restarts at header byte 0 with the position cleared
		cur_phase = file_start ? PH_HEADER : phase_q;
		cur_idx   = file_start ? 4'd0 : idx_q;
		cur_pos   = file_start ? '0 : pos_q;
		pos_inc   = (cur_pos == {POS_W{1'b1}}) ? cur_pos : cur_pos + 1'b1;

		phase_d       = cur_phase;
		idx_d         = cur_idx;
		pos_d         = cur_pos;
		first_d       = first_q;
		major_d       = major_q;
		minor_d       = minor_q;
		size_d        = size_q;
		tag_end_d     = tag_end_q;
		name_d        = name_q;
		len_d         = len_q;
		left_d        = left_q;
		emit_d        = emit_q;
		shown_d       = shown_q;
		frame_final_d = frame_final_q;

		kinds       = '0;
		n           = 3'd0;
		last_flag   = 1'b0;
		do_finish   = 1'b0;
		do_boundary = 1'b0;
		do_term     = 1'b0;
		matched     = 1'b0;
		unsup       = 1'b0;

		case (cur_phase)
			PH_HEADER: begin
				pos_d = pos_inc;
				if (cur_idx == 4'd0)
					first_d = in_byte;
				else if (cur_idx == VER_IDX)
					major_d = in_byte;
				else if (cur_idx == REV_IDX)
					minor_d = in_byte;
				else if (cur_idx >= SIZE_IDX)
					size_d = {size_q[SIZE_W-8:0], in_byte[6:0]};
				if (cur_idx < HDR_LAST_IDX) begin
					idx_d = cur_idx + 4'd1;
				end else begin
					tag_end_d = TAG_END_W'(size_d) + TAG_HDR_LEN;
					if (first_q == BYTE_NO_TAG) begin
						kinds[n[1:0]] = KIND_NO_TAG;
						n = n + 3'd1;
						last_flag = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						kinds[n[1:0]] = KIND_VERSION;
						n = n + 3'd1;
						if (major_q == VER_UNSUPP) begin
							kinds[n[1:0]] = KIND_BAD_VER;
							n = n + 3'd1;
							last_flag = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							do_boundary = 1'b1;
						end
					end
				end
			end
			PH_FRAME_HDR: begin
				pos_d = pos_inc;
				if (cur_idx == 4'd0 && in_byte == 8'd0) begin
					do_term = 1'b1;
				end else begin
					if (cur_idx <= NAME_END_IDX)
						name_d = {name_q[23:0], in_byte};
					else if (cur_idx <= LEN_END_IDX)
						len_d = {len_q[23:0], in_byte};
					if (cur_idx < HDR_LAST_IDX) begin
						idx_d = cur_idx + 4'd1;
					end else begin
						matched = !match_mode || name_q == wanted_frame_id;
						unsup = name_q == ID_APIC || name_q == ID_COMM ||
							name_q[31:16] == ID_TT;
						shown_d       = matched;
						frame_final_d = match_mode && matched;
						emit_d        = matched && !unsup;
						left_d        = len_q;
						if (matched) begin
							kinds[n[1:0]] = KIND_BEGIN;
							n = n + 3'd1;
							if (unsup) begin
								kinds[n[1:0]] = KIND_UNSUP;
								n = n + 3'd1;
							end
						end
						phase_d = PH_VALUE;
						if (len_q == 32'd0)
							do_finish = 1'b1;
					end
				end
			end
			PH_VALUE: begin
				pos_d = pos_inc;
				if (emit_q) begin
					kinds[n[1:0]] = KIND_VALUE;
					n = n + 3'd1;
				end
				left_d = (left_q != 32'd0) ? left_q - 32'd1 : 32'd0;
				if (left_d == 32'd0)
					do_finish = 1'b1;
			end
			default: begin
			end
		endcase

		// end of a frame's value
		if (do_finish) begin
			if (shown_d) begin
				kinds[n[1:0]] = KIND_END;
				n = n + 3'd1;
				last_flag = frame_final_d;
			end
			if (shown_d && frame_final_d)
				phase_d = PH_IDLE;
			else
				do_boundary = 1'b1;
		end

		// next frame header, unless the tag end has been reached
		if (do_boundary) begin
			phase_d = PH_FRAME_HDR;
			idx_d   = 4'd0;
			if (pos_d >= POS_W'(tag_end_d))
				do_term = 1'b1;
		end

		if (do_term) begin
			kinds[n[1:0]] = match_mode ? KIND_NOT_FOUND : KIND_TAG_DONE;
			n = n + 3'd1;
			last_flag = 1'b1;
			phase_d = PH_IDLE;
		end
	end

	always_comb begin
		bundle.kinds    = kinds;
		bundle.count    = n;
		bundle.last     = last_flag;
		bundle.data     = in_byte;
		bundle.name     = name_d;
		bundle.wanted   = wanted_frame_id;
		bundle.version  = major_d;
		bundle.revision = minor_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			idx_q         <= 4'd0;
			first_q       <= 8'd0;
			major_q       <= 8'd0;
			minor_q       <= 8'd0;
			size_q        <= '0;
			tag_end_q     <= '0;
			pos_q         <= '0;
			name_q        <= 32'd0;
			len_q         <= 32'd0;
			left_q        <= 32'd0;
			emit_q        <= 1'b0;
			shown_q       <= 1'b0;
			frame_final_q <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			idx_q         <= idx_d;
			first_q       <= first_d;
			major_q       <= major_d;
			minor_q       <= minor_d;
			size_q        <= size_d;
			tag_end_q     <= tag_end_d;
			pos_q         <= pos_d;
			name_q        <= name_d;
			len_q         <= len_d;
			left_q        <= left_d;
			emit_q        <= emit_d;
			shown_q       <= shown_d;
			frame_final_q <= frame_final_d;
		end
	end

	// a final result always leaves the parser idle
	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && bundle.count != 3'd0 && bundle.last |=> phase_q == PH_IDLE)
		else $error("parser not idle after final result");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= HDR_LAST_IDX)
		else $error("header index out of range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bundle.count <= 3'(MAX_RES))
		else $error("more results than a bundle holds");

endmodule

`default_nettype wire

@@ rtl/core/id3fp_out_buf.sv @@
// id3fp_out_buf: holds one result bundle and hands its results out one
// transaction at a time; uses id3fp_pkg
`default_nettype none

module id3fp_out_buf
	import id3fp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  id3fp_bundle_t      bundle,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [3:0]         kind,
	output logic [7:0]         data_byte,
	output logic [31:0]        frame_id,
	output logic [7:0]         tag_version,
	output logic [7:0]         tag_revision,
	output logic               last
);

	id3fp_bundle_t bund_q;
	logic [2:0]    rem_q;
	logic [1:0]    head_q;

	assign out_valid = rem_q != 3'd0;
	// take a new byte once the held bundle is empty or on its final transaction
	assign in_ready  = rem_q == 3'd0 || (rem_q == 3'd1 && out_ready);

	always_comb begin
		kind         = bund_q.kinds[head_q];
		tag_version  = bund_q.version;
		tag_revision = bund_q.revision;
		last         = bund_q.last && rem_q == 3'd1;
		data_byte    = (kind == KIND_VALUE) ? bund_q.data : 8'd0;
		case (kind) inside
			[KIND_BEGIN:KIND_END]: frame_id = bund_q.name;
			KIND_NOT_FOUND:        frame_id = bund_q.wanted;
			default:               frame_id = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= 3'd0;
			head_q <= 2'd0;
		end else if (load) begin
			rem_q  <= bundle.count;
			head_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			rem_q  <= rem_q - 3'd1;
			head_q <= head_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && bundle.count != 3'd0)
			bund_q <= bundle;
	end

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 3'd0 && !out_ready |=> rem_q == $past(rem_q) && head_q == $past(head_q))
		else $error("bundle changed while output stalled");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(3'(head_q) + rem_q) <= 3'(MAX_RES))
		else $error("result slot beyond bundle");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with nothing to send");

endmodule

`default_nettype wire

@@ rtl/core/id3v2_frame_parser.sv @@
// id3v2_frame_parser: streaming id3v2 tag and frame header parser
// the first result of a byte is offered in the cycle after its accepting edge
// throughput: one byte per cycle while the output is ready and no byte gives more
//   than one result; with n results (n up to 4) the input waits for the last one
// reset: arst_n is asynchronous, active low; it clears the parser state, the
//   configuration registers and the output buffer
`default_nettype none

module id3v2_frame_parser
	import id3fp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	id3fp_in_if.sink         in_ch,
	id3fp_out_if.source      out_ch
);

	// configuration registers; the user must write them only while the parser is quiet, which the block does not enforce
	logic          match_mode_q;
	logic [31:0]   wanted_id_q;

	// a byte transaction on the input channel
	logic          step;
	logic          buf_ready;
	id3fp_bundle_t bundle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_mode_q <= 1'b0;
			wanted_id_q  <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MATCH_MODE: match_mode_q <= cfg_wdata[0];
				CFG_WANTED_ID:  wanted_id_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign in_ch.ready = buf_ready;
	assign step        = in_ch.valid && buf_ready;

	// header and frame walk; all state updates happen at the accepting edge
	id3fp_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.in_byte         (in_ch.in_byte),
		.file_start      (in_ch.file_start),
		.match_mode      (match_mode_q),
		.wanted_frame_id (wanted_id_q),
		.bundle          (bundle)
	);

	// result register: holds the bundle and drains it one transaction a cycle while out_ch is ready
	id3fp_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step),
		.bundle       (bundle),
		.in_ready     (buf_ready),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.kind         (out_ch.kind),
		.data_byte    (out_ch.data_byte),
		.frame_id     (out_ch.frame_id),
		.tag_version  (out_ch.tag_version),
		.tag_revision (out_ch.tag_revision),
		.last         (out_ch.last)
	);

endmodule

`default_nettype wire

@@ test/tb_id3v2_frame_parser.sv @@
`timescale 1ns / 1ps
// tb_id3v2_frame_parser: self-checking testbench for the id3v2 frame parser
// depends on id3fp_pkg, the id3fp_in_if / id3fp_out_if channels and the parser rtl

module tb_id3v2_frame_parser;
	import id3fp_pkg::*;

	// one file byte as offered on the input channel
	typedef struct packed {
		logic [7:0] in_byte;
		logic       file_start;
	} file_byte_t;

	// one parser report as seen on the output channel
	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  data;
		logic [31:0] id;
		logic [7:0]  version;
		logic [7:0]  revision;
		logic        last;
	} parse_report_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;

	id3fp_in_if  in_ch();
	id3fp_out_if out_ch();

	id3v2_frame_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// bytes waiting for the driver, reports waiting for the monitor
	file_byte_t    byte_feed[$];
	logic [7:0]    file_bytes[$];
	parse_report_t expected_reports[$];

	file_byte_t  next_byte;
	logic        in_taken = 1'b0;
	logic        rx_hold = 1'b0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          phase_no = 0;
	int unsigned bytes_queued = 0;
	int unsigned mismatches = 0;

	// shadow of the configuration registers
	logic        shadow_mode;
	logic [31:0] shadow_wanted;

	// parser state as predicted
	logic [1:0]  prs_phase;
	logic [3:0]  prs_index;
	logic [7:0]  prs_first;
	logic [7:0]  prs_version;
	logic [7:0]  prs_revision;
	logic [27:0] prs_size;
	logic [28:0] prs_tag_end;
	logic [32:0] prs_position;
	logic [31:0] prs_name;
	logic [31:0] prs_len;
	logic [31:0] prs_left;
	logic        prs_emit;
	logic        prs_shown;
	logic        prs_final;

	// ------------------------------------------------------------------
	// parse prediction
	// ------------------------------------------------------------------

	function automatic void clear_parse();
		prs_phase    = PH_HEADER;
		prs_index    = '0;
		prs_first    = '0;
		prs_version  = '0;
		prs_revision = '0;
		prs_size     = '0;
		prs_tag_end  = '0;
		prs_position = '0;
		prs_name     = '0;
		prs_len      = '0;
		prs_left     = '0;
		prs_emit     = 1'b0;
		prs_shown    = 1'b0;
		prs_final    = 1'b0;
	endfunction

	// every report carries the header bytes held so far
	function automatic void post_report(logic [3:0] kind, logic [7:0] data, logic [31:0] id,
		logic last);
		parse_report_t r;
		r.kind     = kind;
		r.data     = data;
		r.id       = id;
		r.version  = prs_version;
		r.revision = prs_revision;
		r.last     = last;
		expected_reports.push_back(r);
	endfunction

	// end of the tag: get mode reports the wanted frame as missing
	function automatic void close_tag();
		if (shadow_mode)
			post_report(KIND_NOT_FOUND, 8'h00, shadow_wanted, 1'b1);
		else
			post_report(KIND_TAG_DONE, 8'h00, 32'h0, 1'b1);
		prs_phase = PH_IDLE;
	endfunction

	function automatic void frame_boundary();
		prs_phase = PH_FRAME_HDR;
		prs_index = '0;
		if (prs_position >= prs_tag_end)
			close_tag();
	endfunction

	function automatic void finish_frame();
		if (prs_shown) begin
			post_report(KIND_END, 8'h00, prs_name, prs_final);
			if (prs_final) begin
				prs_phase = PH_IDLE;
				return;
			end
		end
		frame_boundary();
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic start);
		logic matched;
		logic unsup;
		if (start)
			clear_parse();
		if (prs_phase == PH_IDLE)
			return;
		if (prs_position != '1)
			prs_position = prs_position + 1'b1;

		case (prs_phase)
			PH_HEADER: begin
				if (prs_index == 4'd0)
					prs_first = b;
				else if (prs_index == VER_IDX)
					prs_version = b;
				else if (prs_index == REV_IDX)
					prs_revision = b;
				else if (prs_index >= SIZE_IDX)
					prs_size = {prs_size[20:0], b[6:0]};
				if (prs_index < HDR_LAST_IDX) begin
					prs_index = prs_index + 1'b1;
					return;
				end
				prs_tag_end = {1'b0, prs_size} + TAG_HDR_LEN;
				if (prs_first == BYTE_NO_TAG) begin
					post_report(KIND_NO_TAG, 8'h00, 32'h0, 1'b1);
					prs_phase = PH_IDLE;
					return;
				end
				post_report(KIND_VERSION, 8'h00, 32'h0, 1'b0);
				if (prs_version == VER_UNSUPP) begin
					post_report(KIND_BAD_VER, 8'h00, 32'h0, 1'b1);
					prs_phase = PH_IDLE;
					return;
				end
				frame_boundary();
			end
			PH_FRAME_HDR: begin
				// a zero first name byte is padding: the tag is over
				if (prs_index == 4'd0 && b == 8'h00) begin
					close_tag();
					return;
				end
				if (prs_index <= NAME_END_IDX)
					prs_name = {prs_name[23:0], b};
				else if (prs_index <= LEN_END_IDX)
					prs_len = {prs_len[23:0], b};
				if (prs_index < HDR_LAST_IDX) begin
					prs_index = prs_index + 1'b1;
					return;
				end
				matched   = !shadow_mode || prs_name == shadow_wanted;
				unsup     = prs_name == ID_APIC || prs_name == ID_COMM ||
					prs_name[31:16] == ID_TT;
				prs_shown = matched;
				prs_final = shadow_mode && matched;
				prs_emit  = matched && !unsup;
				prs_left  = prs_len;
				if (matched) begin
					post_report(KIND_BEGIN, 8'h00, prs_name, 1'b0);
					if (unsup)
						post_report(KIND_UNSUP, 8'h00, prs_name, 1'b0);
				end
				prs_phase = PH_VALUE;
				// zero-length frame closes in the same byte
				if (prs_left == 32'h0)
					finish_frame();
			end
			default: begin
				if (prs_emit)
					post_report(KIND_VALUE, b, prs_name, 1'b0);
				if (prs_left != 32'h0)
					prs_left = prs_left - 1'b1;
				if (prs_left == 32'h0)
					finish_frame();
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// file construction
	// ------------------------------------------------------------------

	// header goes in front of whatever frame bytes are already staged
	task automatic stage_header(logic [7:0] first, logic [7:0] ver, logic [7:0] rev,
		logic [27:0] tag_size);
		logic [7:0] hdr[10];
		int i;
		hdr[0] = first;
		hdr[1] = 8'h44; // 'D'
		hdr[2] = 8'h33; // '3'
		hdr[3] = ver;
		hdr[4] = rev;
		hdr[5] = 8'($urandom_range(255));
		// syncsafe size, bit 7 of each byte is junk the parser must drop
		for (i = 0; i < 4; i++)
			hdr[6 + i] = {1'($urandom), 7'(tag_size >> (21 - 7 * i))};
		for (i = 9; i >= 0; i--)
			file_bytes.push_front(hdr[i]);
	endtask

	task automatic stage_frame(logic [31:0] name, logic [31:0] len, int unsigned nval);
		int i;
		int unsigned pick;
		for (i = 3; i >= 0; i--)
			file_bytes.push_back(name[8*i +: 8]);
		for (i = 3; i >= 0; i--)
			file_bytes.push_back(len[8*i +: 8]);
		file_bytes.push_back(8'($urandom_range(255)));
		file_bytes.push_back(8'($urandom_range(255)));
		for (i = 0; i < nval; i++) begin
			pick = $urandom_range(9);
			file_bytes.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF :
				8'($urandom_range(255)));
		end
	endtask

	// hand the staged file to the driver, file_start on its first byte
	task automatic commit_file();
		int i;
		for (i = 0; i < file_bytes.size(); i++)
			byte_feed.push_back({file_bytes[i], i == 0});
		bytes_queued += file_bytes.size();
		file_bytes.delete();
	endtask

	task automatic queue_file();
		int unsigned shape;
		int unsigned pick;
		int unsigned nframes;
		int unsigned nval;
		int unsigned body_len;
		int unsigned cut;
		int          f;
		bit          broken;
		logic [7:0]  first;
		logic [7:0]  ver;
		logic [27:0] tag_size;
		logic [31:0] name;
		logic [31:0] len;

		shape  = $urandom_range(99);
		broken = 1'b0;
		if (shape < 8)
			first = BYTE_NO_TAG;
		else if (shape < 14)
			first = 8'($urandom_range(254));
		else
			first = 8'h49; // 'I'
		if (shape >= 8 && shape < 16) begin
			ver = VER_UNSUPP;
		end else begin
			pick = $urandom_range(9);
			ver  = pick < 5 ? 8'd3 : pick < 8 ? 8'd4 : 8'($urandom_range(255));
		end

		nframes = $urandom_range(4);
		for (f = 0; f < nframes && !broken; f++) begin
			pick = $urandom_range(99);
			if (pick < 20)
				name = shadow_wanted;
			else if (pick < 30)
				name = ID_APIC;
			else if (pick < 40)
				name = ID_COMM;
			else if (pick < 50)
				name = {ID_TT, 16'($urandom)};
			else if (pick < 58)
				name = $urandom;
			else if (pick < 62)
				name = {8'h00, 24'($urandom)};
			else
				name = {8'h41 + 8'($urandom_range(25)), 8'h41 + 8'($urandom_range(25)),
					8'h41 + 8'($urandom_range(25)), 8'h30 + 8'($urandom_range(9))};
			// now and then a huge length, the file is cut off inside the value
			if ($urandom_range(99) < 5) begin
				len  = $urandom;
				nval = $urandom_range(8);
				if (len <= nval)
					nval = len;
				else
					broken = 1'b1;
			end else begin
				len  = $urandom_range(5);
				nval = len;
			end
			stage_frame(name, len, nval);
		end

		body_len = file_bytes.size();
		pick     = $urandom_range(99);
		if (pick < 50) begin
			tag_size = 28'(body_len);
		end else if (pick < 70) begin
			tag_size = 28'(body_len + 1 + $urandom_range(4));
			file_bytes.push_back(8'h00);
		end else if (pick < 85) begin
			tag_size = 28'($urandom_range(body_len));
		end else begin
			tag_size = 28'($urandom);
		end
		stage_header(first, ver, 8'($urandom_range(255)), tag_size);

		// trailing bytes, mostly seen by an idle parser
		repeat ($urandom_range(2))
			file_bytes.push_back(8'($urandom_range(255)));
		if ($urandom_range(99) < 5) begin
			cut = $urandom_range(file_bytes.size() - 1, 1);
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
		commit_file();
	endtask

	// ------------------------------------------------------------------
	// configuration and phase control
	// ------------------------------------------------------------------

	task automatic write_reg(logic index, logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		if (index == CFG_MATCH_MODE)
			shadow_mode = value[0];
		else
			shadow_wanted = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// all bytes taken, all reports seen, then a wait for bytes that
	// gave nothing but may still be in flight
	task automatic settle();
		while (byte_feed.size() != 0 || in_ch.valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// input driver: offers bytes at the falling edge, holds until taken
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_taken) begin
				if (byte_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_byte = byte_feed.pop_front();
					in_ch.valid      <= 1'b1;
					in_ch.in_byte    <= next_byte.in_byte;
					in_ch.file_start <= next_byte.file_start;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// input transaction seen at the rising edge: predict its reports
	always @(posedge clk) begin
		in_taken <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready)
			parse_byte(in_ch.in_byte, in_ch.file_start);
	end

	// ------------------------------------------------------------------
	// output monitor: random backpressure, field checks against the oldest report
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n)
			out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		parse_report_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_reports.size() == 0) begin
				note_mismatch("unexpected report, kind", 32'(out_ch.kind), 32'h0);
			end else begin
				want = expected_reports.pop_front();
				if (out_ch.kind !== want.kind)
					note_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
				if (out_ch.data_byte !== want.data)
					note_mismatch("data_byte", 32'(out_ch.data_byte), 32'(want.data));
				if (out_ch.frame_id !== want.id)
					note_mismatch("frame_id", out_ch.frame_id, want.id);
				if (out_ch.tag_version !== want.version)
					note_mismatch("tag_version", 32'(out_ch.tag_version), 32'(want.version));
				if (out_ch.tag_revision !== want.revision)
					note_mismatch("tag_revision", 32'(out_ch.tag_revision),
						32'(want.revision));
				if (out_ch.last !== want.last)
					note_mismatch("last", 32'(out_ch.last), 32'(want.last));
			end
		end
	end

	// ------------------------------------------------------------------
	// long receiver stall with the sender still pushing, so the parser
	// output fills up and the input channel backs off
	// ------------------------------------------------------------------

	initial begin
		wait (phase_no == 4);
		repeat (12) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (250) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	initial begin
		int          ph;
		int unsigned goal;
		logic        mode_sel;
		logic [31:0] wanted_sel;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_MATCH_MODE;
		cfg_wdata        = 32'h0;
		in_ch.valid      = 1'b0;
		in_ch.in_byte    = 8'h00;
		in_ch.file_start = 1'b0;
		out_ch.ready     = 1'b0;
		shadow_mode      = 1'b0;
		shadow_wanted    = 32'h0;
		clear_parse();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (ph = 0; ph < 6; ph++) begin
			settle();
			// settings per phase: show all, get a text frame, get all-ones id,
			// show with a random id, get an unsupported frame, get a zero id
			case (ph)
				0: begin mode_sel = 1'b0; wanted_sel = 32'h0; end
				1: begin mode_sel = 1'b1; wanted_sel = 32'h54495432; end
				2: begin mode_sel = 1'b1; wanted_sel = 32'hFFFFFFFF; end
				3: begin mode_sel = 1'b0; wanted_sel = $urandom; end
				4: begin mode_sel = 1'b1; wanted_sel = ID_APIC; end
				default: begin mode_sel = 1'b1; wanted_sel = 32'h0; end
			endcase
			write_reg(CFG_MATCH_MODE, {31'h0, mode_sel});
			write_reg(CFG_WANTED_ID, wanted_sel);

			// idling: sender light / receiver heavy, then swapped, then none
			@(posedge clk);
			phase_no    <= ph;
			tx_idle_pct <= ph < 2 ? 22 : ph < 4 ? 63 : 0;
			rx_idle_pct <= ph < 2 ? 63 : ph < 4 ? 22 : 0;
			@(posedge clk);

			if (ph == 0) begin
				// missing tag, extreme header bytes
				stage_header(BYTE_NO_TAG, 8'hFF, 8'h00, 28'hFFFFFFF);
				commit_file();
				// unsupported version 2
				stage_header(8'h49, VER_UNSUPP, 8'hFF, 28'h0);
				commit_file();
				// empty unsupported frame that also ends the tag: four reports
				// from its last header byte
				stage_frame(ID_APIC, 32'h0, 0);
				stage_header(8'h49, 8'd3, 8'h00, 28'd10);
				commit_file();
			end

			goal = bytes_queued + 36;
			while (bytes_queued < goal)
				queue_file();
		end

		settle();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("tb_id3v2_frame_parser: clean");
		else
			$display("tb_id3v2_frame_parser: errors");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("tb_id3v2_frame_parser: errors");
		$finish;
	end

endmodule
